// ----- hdl/hfq_pkg.sv -----
// Shared types and constants for the Hilbert FIR quadrature pair.
package hfq_pkg;

  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 16;
  localparam int INDEX_W  = 7;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int RND_SHIFT = 15;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic [SAMPLE_W-1:0] Q31_MAX = 32'h7fff_ffff;
  localparam logic [SAMPLE_W-1:0] Q31_MIN = 32'h8000_0000;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [INDEX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0]   coef_value;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] quadrature_out;
    logic signed [SAMPLE_W-1:0] in_phase_out;
  } out_t;

endpackage

// ----- hdl/hfq_ram.sv -----
// Generic simple dual-port RAM with registered read.
module hfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/hilbert_fir_quadrature_pair.sv -----
// Hilbert FIR quadrature pair: top level with history and coefficient memories.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one transaction per
// command. A load command (cmd = 1) writes one Q1.15 coefficient in the accept
// cycle and returns nothing; an index of TAPS or more is dropped. A sample command
// pushes a Q31 sample into the history and yields one result transaction on the
// output channel (out_valid_o / out_stall_i / out_data_o): the rounded, saturated
// FIR sum and the input delayed by (TAPS-1)/2 samples.
// A sample runs one MAC per tap, reading one history word and one coefficient per
// cycle from the two RAMs, then the multiply, accumulate and rounding stages after
// the last read. in_stall_o stays high from the accept of a sample until its result
// enters the output register, so no transaction is taken in between; loads run at
// one per cycle while the filter is idle.
// The result waits in an output register while out_stall_i is high; the next
// transaction is taken meanwhile, and a new result only waits for that register.
// Reset clears the history pointer and the per-entry valid bits of both memories,
// so history and coefficients read as zero until written; no clearing pass.
module hilbert_fir_quadrature_pair #(
  parameter int TAPS = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hfq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hfq_pkg::out_t out_data_o
);

  localparam int IDX_W = $clog2(TAPS);
  localparam int ACC_W = hfq_pkg::PROD_W + $clog2(TAPS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
  localparam logic [IDX_W-1:0] MID_IDX  = IDX_W'(TAPS - 1 - (TAPS - 1) / 2);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_e;

  state_e                  state_q;
  logic [IDX_W-1:0]        ptr_q;
  logic [IDX_W-1:0]        slot_q;
  logic [IDX_W-1:0]        cnt_q;
  logic [TAPS-1:0]         hist_vld_q;
  logic [TAPS-1:0]         coef_vld_q;
  logic                    s1_vld_q, s1_last_q, s1_mid_q;
  logic                    s2_vld_q, s2_last_q;
  logic                    fin_q;
  logic                    hv_q, cv_q;
  logic                    out_vld_q;
  hfq_pkg::out_t           out_q;

  logic signed [hfq_pkg::PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]             acc_q;
  logic signed [hfq_pkg::SAMPLE_W-1:0] inph_q;

  logic                                in_acc, smp_acc, ld_ok, issue, out_free, out_load;
  logic [hfq_pkg::SAMPLE_W-1:0]        hist_rdata;
  logic [hfq_pkg::COEF_W-1:0]          coef_rdata;
  logic signed [hfq_pkg::SAMPLE_W-1:0] h_val;
  logic signed [hfq_pkg::COEF_W-1:0]   c_val;
  logic signed [ACC_W-1:0]             rnd_sum, rnd_val;
  logic [hfq_pkg::SAMPLE_W-1:0]        sat_val;
  logic                                rnd_fits;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign smp_acc    = in_acc && (in_data_i.cmd == hfq_pkg::CMD_SAMPLE);
  assign ld_ok      = in_acc && (in_data_i.cmd == hfq_pkg::CMD_LOAD) &&
                      (32'(in_data_i.coef_index) < TAPS);
  assign issue      = (state_q == ST_RUN);
  assign out_free   = !out_vld_q || !out_stall_i;
  assign out_load   = (state_q == ST_FLUSH) && fin_q && out_free;

  hfq_ram #(.WIDTH(hfq_pkg::SAMPLE_W), .DEPTH(TAPS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (smp_acc),
    .waddr_i (ptr_q),
    .wdata_i (in_data_i.sample_in),
    .raddr_i (slot_q),
    .rdata_o (hist_rdata)
  );

  hfq_ram #(.WIDTH(hfq_pkg::COEF_W), .DEPTH(TAPS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ld_ok),
    .waddr_i (in_data_i.coef_index[IDX_W-1:0]),
    .wdata_i (in_data_i.coef_value),
    .raddr_i (cnt_q),
    .rdata_o (coef_rdata)
  );

  assign h_val = hv_q ? $signed(hist_rdata) : '0;
  assign c_val = cv_q ? $signed(coef_rdata) : '0;

  // round half up, floor shift, saturate to Q31
  assign rnd_sum  = acc_q + ACC_W'(1 << (hfq_pkg::RND_SHIFT - 1));
  assign rnd_val  = rnd_sum >>> hfq_pkg::RND_SHIFT;
  assign rnd_fits = (rnd_val[ACC_W-1:hfq_pkg::SAMPLE_W-1] == '0) ||
                    (rnd_val[ACC_W-1:hfq_pkg::SAMPLE_W-1] == '1);
  assign sat_val  = rnd_fits ? rnd_val[hfq_pkg::SAMPLE_W-1:0] :
                    (rnd_val[ACC_W-1] ? hfq_pkg::Q31_MIN : hfq_pkg::Q31_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ptr_q      <= '0;
      slot_q     <= '0;
      cnt_q      <= '0;
      hist_vld_q <= '0;
      coef_vld_q <= '0;
      s1_vld_q   <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_mid_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_last_q  <= 1'b0;
      fin_q      <= 1'b0;
      hv_q       <= 1'b0;
      cv_q       <= 1'b0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      s1_vld_q  <= issue;
      s1_last_q <= issue && (cnt_q == LAST_IDX);
      s1_mid_q  <= issue && (cnt_q == MID_IDX);
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
      hv_q      <= hist_vld_q[slot_q];
      cv_q      <= coef_vld_q[cnt_q];
      if (s2_vld_q && s2_last_q) begin
        fin_q <= 1'b1;
      end
      if (ld_ok) begin
        coef_vld_q[in_data_i.coef_index[IDX_W-1:0]] <= 1'b1;
      end
      if (out_vld_q && !out_stall_i && !out_load) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (smp_acc) begin
            hist_vld_q[ptr_q] <= 1'b1;
            slot_q  <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
            ptr_q   <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          slot_q <= (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
          cnt_q  <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
          if (cnt_q == LAST_IDX) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (out_load) begin
            fin_q                <= 1'b0;
            out_vld_q            <= 1'b1;
            out_q.quadrature_out <= sat_val;
            out_q.in_phase_out   <= inph_q;
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= h_val * c_val;
    if (s1_mid_q) begin
      inph_q <= h_val;
    end
    if (smp_acc) begin
      acc_q <= '0;
    end else if (s2_vld_q) begin
      acc_q <= acc_q + {{(ACC_W - hfq_pkg::PROD_W){prod_q[hfq_pkg::PROD_W-1]}}, prod_q};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/hfq_checker.sv -----
// Port-level checker for the Hilbert FIR quadrature pair, bound to the top level.
module hfq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input hfq_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input hfq_pkg::out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.cmd == hfq_pkg::CMD_SAMPLE) |=> in_stall_o)
    else $error("sample transaction did not start the filter");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.cmd == hfq_pkg::CMD_LOAD) |=> !in_stall_o)
    else $error("load transaction stalled the input");

  a_result_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $fell(in_stall_o))
    else $error("result appeared outside the end of a sample");

endmodule

bind hilbert_fir_quadrature_pair hfq_checker u_hfq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the Hilbert FIR quadrature pair: directed and random commands checked against a local model.
module tb_top;

  localparam int TAPS         = 31;
  localparam int HALF_DELAY   = (TAPS - 1) / 2;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = TAPS + 8;
  localparam longint Q31_HI   = 64'sd2147483647;
  localparam longint Q31_LO   = -64'sd2147483648;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  hfq_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  hfq_pkg::out_t out_data;

  logic idle_on;
  int   fail_count = 0;
  int   cycle_count = 0;

  logic signed [hfq_pkg::SAMPLE_W-1:0] hist [TAPS];
  logic signed [hfq_pkg::COEF_W-1:0]   coefs [TAPS];
  int            hist_ptr;
  hfq_pkg::out_t pending_pairs [$];

  hilbert_fir_quadrature_pair #(.TAPS(TAPS)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Updates the filter state for one command; a sample also queues its quadrature pair.
  task automatic hilbert_update(input hfq_pkg::in_t t);
    longint        acc;
    longint        rounded;
    hfq_pkg::out_t pair;
    if (t.cmd == hfq_pkg::CMD_LOAD) begin
      if (t.coef_index < TAPS) coefs[t.coef_index] = t.coef_value;
      return;
    end
    hist[hist_ptr] = t.sample_in;
    acc = 0;
    // coefs[0] weights the oldest sample, coefs[TAPS-1] the newest
    for (int i = 0; i < TAPS; i++) begin
      acc += longint'(hist[(hist_ptr + 1 + i) % TAPS]) * longint'(coefs[i]);
    end
    rounded = (acc + 64'sd16384) >>> hfq_pkg::RND_SHIFT;
    if (rounded > Q31_HI) pair.quadrature_out = hfq_pkg::Q31_MAX;
    else if (rounded < Q31_LO) pair.quadrature_out = hfq_pkg::Q31_MIN;
    else pair.quadrature_out = rounded[hfq_pkg::SAMPLE_W-1:0];
    pair.in_phase_out = hist[(hist_ptr + TAPS - HALF_DELAY) % TAPS];
    hist_ptr = (hist_ptr + 1) % TAPS;
    pending_pairs.push_back(pair);
  endtask

  task automatic send_item(input hfq_pkg::in_t t);
    @(negedge clk);
    while (idle_on && ($urandom_range(99) < 20)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    hilbert_update(t);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_pairs.size() == 0);
  endtask

  function automatic hfq_pkg::in_t make_sample(input logic [hfq_pkg::SAMPLE_W-1:0] value);
    hfq_pkg::in_t t;
    t.cmd        = hfq_pkg::CMD_SAMPLE;
    t.sample_in  = value;
    t.coef_index = 7'($urandom);
    t.coef_value = 16'($urandom);
    return t;
  endfunction

  function automatic hfq_pkg::in_t make_load(input logic [hfq_pkg::INDEX_W-1:0] idx,
                                             input logic [hfq_pkg::COEF_W-1:0] value);
    hfq_pkg::in_t t;
    t.cmd        = hfq_pkg::CMD_LOAD;
    t.sample_in  = $urandom;
    t.coef_index = idx;
    t.coef_value = value;
    return t;
  endfunction

  function automatic logic [hfq_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return hfq_pkg::Q31_MAX;
      1:       return hfq_pkg::Q31_MIN;
      2:       return $urandom_range(255) - 128;
      default: return $urandom;
    endcase
  endfunction

  function automatic hfq_pkg::in_t rand_item();
    logic [hfq_pkg::INDEX_W-1:0] idx;
    logic [hfq_pkg::COEF_W-1:0]  value;
    if ($urandom_range(99) >= 15) return make_sample(rand_sample());
    if ($urandom_range(9) == 0) idx = 7'($urandom_range(127, TAPS));
    else idx = 7'($urandom_range(TAPS - 1));
    case ($urandom_range(7))
      0:       value = 16'h7fff;
      1:       value = 16'h8000;
      default: value = 16'($urandom);
    endcase
    return make_load(idx, value);
  endfunction

  task automatic test_history_delay();
    send_item(make_sample('0));
    send_item(make_sample(hfq_pkg::Q31_MAX));
    send_item(make_sample(hfq_pkg::Q31_MIN));
    send_item(make_sample('1));
    send_item(make_sample(32'd1));
  endtask

  task automatic test_coef_load_saturation();
    send_item(make_load(7'd0, 16'h8000));
    send_item(make_load(7'd29, 16'h7fff));
    send_item(make_load(7'd30, 16'h7fff));
    send_item(make_load(7'd31, 16'h7fff));
    send_item(make_load(7'd127, 16'h8000));
    send_item(make_sample(hfq_pkg::Q31_MAX));
    send_item(make_sample(hfq_pkg::Q31_MAX));
    send_item(make_sample(hfq_pkg::Q31_MIN));
    send_item(make_sample(hfq_pkg::Q31_MIN));
    send_item(make_load(7'd30, 16'h0000));
    send_item(make_sample(32'h1234_5678));
    drain_results();
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) send_item(rand_item());
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    for (int n = 0; n < count; n++) send_item(rand_item());
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && idle_on && ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin
    hfq_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_data.quadrature_out !== want.quadrature_out) begin
          $error("quadrature_out: expected %0d, actual %0d",
                 want.quadrature_out, out_data.quadrature_out);
          fail_count++;
        end
        if (out_data.in_phase_out !== want.in_phase_out) begin
          $error("in_phase_out: expected %0d, actual %0d",
                 want.in_phase_out, out_data.in_phase_out);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL hilbert_fir_quadrature_pair");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    idle_on     = 1'b1;
    hist_ptr    = 0;
    for (int i = 0; i < TAPS; i++) begin
      hist[i]  = '0;
      coefs[i] = '0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_history_delay();
    test_coef_load_saturation();
    test_random_traffic(350);
    test_back_to_back(200);
    test_random_traffic(300);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS hilbert_fir_quadrature_pair");
    end else begin
      $display("FAIL hilbert_fir_quadrature_pair");
    end
    $finish;
  end

endmodule
